FILE: rtl/fwpr_pkg.sv
// shared types and constants for the indexed-access fifo
`timescale 1ns / 1ps

package fwpr_pkg;

  // queue geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // fixed field widths of the stream beats
  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // stream packing
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 104;

  // request kinds
  typedef enum logic [1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_DEQUEUE = 2'd1,
    REQ_READ    = 2'd2,
    REQ_REMOVE  = 2'd3
  } req_e;

  typedef struct packed {
    req_e               req_type;
    logic [WORD_W-1:0]  data_in;
    logic [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [WORD_W-1:0]  read_data;
    logic [WORD_W-1:0]  head_data;
    logic [WORD_W-1:0]  tail_data;
    logic               not_empty;
    logic [4:0]         entry_count;
  } rsp_t;

endpackage

FILE: rtl/fwpr_cells.sv
// register cells of the queue with enqueue, dequeue, indexed read and remove
`timescale 1ns / 1ps

module fwpr_cells (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  fwpr_pkg::req_t req_i,
  output fwpr_pkg::rsp_t rsp_o
);
  import fwpr_pkg::*;

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic [DATA_W-1:0] entry_d [DEPTH];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DATA_W-1:0] tail_q, tail_d;

  logic [CMP_W-1:0]  pos_cmp;
  logic [CMP_W-1:0]  cnt_cmp;
  logic              pos_hit;
  logic              pos_last;
  logic              full;
  logic              empty;
  logic [IDX_W-1:0]  pos_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic [DATA_W-1:0] rd_word;
  logic [DATA_W-1:0] wr_word;
  logic              enq_ok, deq_ok, read_ok, rem_ok, drop;
  logic [IDX_W-1:0]  drop_idx;
  logic [IDX_W-1:0]  cnt_idx;

  // position checks against the current fill
  assign pos_cmp  = CMP_W'(req_i.position);
  assign cnt_cmp  = CMP_W'(count_q);
  assign pos_hit  = pos_cmp < cnt_cmp;
  assign pos_last = (pos_cmp + CMP_W'(1)) == cnt_cmp;
  assign full     = count_q == CNT_W'(DEPTH);
  assign empty    = count_q == '0;
  assign pos_idx  = IDX_W'(req_i.position);
  assign cnt_idx  = count_q[IDX_W-1:0];
  assign wr_word  = DATA_W'(req_i.data_in);

  // request decode
  assign enq_ok  = (req_i.req_type == REQ_ENQUEUE) && !full;
  assign deq_ok  = (req_i.req_type == REQ_DEQUEUE) && !empty;
  assign read_ok = (req_i.req_type == REQ_READ)    && pos_hit;
  assign rem_ok  = (req_i.req_type == REQ_REMOVE)  && pos_hit;
  assign drop    = deq_ok || rem_ok;
  assign drop_idx = deq_ok ? '0 : pos_idx;

  // single read port: the requested entry, or the new tail on a remove
  assign rd_idx  = (req_i.req_type == REQ_REMOVE) ? (cnt_idx - IDX_W'(2)) : pos_idx;
  assign rd_word = entry_q[rd_idx];

  // next contents of each cell: write at the tail slot or close the gap
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_d[i] = entry_q[i];
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      if (drop && (IDX_W'(i) >= drop_idx)) begin
        entry_d[i] = entry_q[i+1];
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (enq_ok && (IDX_W'(i) == cnt_idx)) begin
        entry_d[i] = wr_word;
      end
    end
  end

  // tail word and fill count
  always_comb begin
    tail_d  = tail_q;
    count_d = count_q;
    if (enq_ok) begin
      tail_d  = wr_word;
      count_d = count_q + CNT_W'(1);
    end else if (drop) begin
      count_d = count_q - CNT_W'(1);
      if (rem_ok && pos_last) begin
        tail_d = rd_word;
      end
    end
  end

  // result of this request
  always_comb begin
    rsp_o.ok          = enq_ok || drop || read_ok;
    rsp_o.read_data   = read_ok ? WORD_W'(rd_word) : '0;
    rsp_o.not_empty   = count_d != '0;
    rsp_o.head_data   = (count_d != '0) ? WORD_W'(entry_d[0]) : '0;
    rsp_o.tail_data   = (count_d != '0) ? WORD_W'(tail_d) : '0;
    rsp_o.entry_count = 5'(count_d);
  end

  // cell storage, no reset on payload
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      for (int i = 0; i < DEPTH; i++) begin
        entry_q[i] <= entry_d[i];
      end
      tail_q <= tail_d;
    end
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
    end
  end

endmodule

FILE: rtl/fifo_with_positional_read_remove.sv
// An accepted beat is captured in the input register; its request is then decoded
// and applied to the register cells, and the result is captured in the result
// register, from which the result beat is presented on m_axis.
// Throughput: one request per cycle, held back only by m_axis_tready.
// Reset: rst_ni (asynchronous, active low) empties the queue and drops
// any beat in flight; stored words are undefined until written.
`timescale 1ns / 1ps

module fifo_with_positional_read_remove (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] data_in, [35:32] position, [39:36] zero
  input  logic [fwpr_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [fwpr_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] ok, [32:1] read_data, [64:33] head_data, [96:65] tail_data,
  // [97] not_empty, [102:98] entry_count, [103] zero
  output logic [fwpr_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import fwpr_pkg::*;

  logic in_vld_q;
  req_t req_q;
  logic out_vld_q;
  rsp_t rsp_q;
  rsp_t rsp;
  logic adv;
  logic fire;
  logic s_acc;

  // handshake
  assign adv           = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && adv;
  assign s_axis_tready = !in_vld_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_acc) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      req_q.req_type <= req_e'(s_axis_tuser[1:0]);
      req_q.data_in  <= s_axis_tdata[WORD_W-1:0];
      req_q.position <= s_axis_tdata[WORD_W+POS_W-1:WORD_W];
    end
  end

  // queue cells
  fwpr_cells u_cells (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp;
    end
  end

  // output beat packing
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, rsp_q.entry_count, rsp_q.not_empty, rsp_q.tail_data,
                          rsp_q.head_data, rsp_q.read_data, rsp_q.ok};

endmodule

FILE: rtl/fwpr_checker.sv
// port-level checks for the indexed-access fifo, bound to the top level
`timescale 1ns / 1ps

module fwpr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [fwpr_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import fwpr_pkg::*;

  // count never exceeds the depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[102:98] <= 5'(DEPTH)))
    else $error("entry count above depth");

  // not_empty flag follows the count
  a_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[97] == (m_axis_tdata[102:98] != 5'd0)))
    else $error("not_empty disagrees with entry count");

  // empty queue shows zero head and tail words
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[97]) |->
      (m_axis_tdata[96:33] == 64'd0))
    else $error("head or tail word not zero on empty queue");

  // failed request reads nothing
  a_fail_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[32:1] == 32'd0))
    else $error("read data on failed request");

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result beat changed while stalled");

endmodule

bind fifo_with_positional_read_remove fwpr_checker u_fwpr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
